/* design/lsf_pkg.sv */
// Shared types, constants and helpers for the line substring filter.
package lsf_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int PAT_BYTES       = 16;
	localparam int LEN_REG_W       = 5;
	localparam int CFG_INDEX_W     = 3;
	localparam int RESULT_DEPTH    = 3;

	typedef logic [PAT_BYTES-1:0][7:0] pattern_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PAT_LOW  = 3'd0,
		CFG_PAT_HIGH = 3'd1,
		CFG_PAT_LEN  = 3'd2,
		CFG_FOLD     = 3'd3,
		CFG_INVERT   = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic selected;
		logic matched;
	} result_t;

	// ASCII A..Z to lower case when folding is on
	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
		logic [7:0] r;
		r = b;
		if (en && (b >= 8'h41) && (b <= 8'h5A)) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage

/* design/lsf_cell.sv */
// One window cell: holds one line byte, passes it on, compares it to its pattern byte.
module lsf_cell #(
	parameter int IDX   = 0,
	parameter int LEN_W = 5
) (
	input  logic               clk,
	input  logic               shift_en,
	input  logic [7:0]         byte_in,
	output logic [7:0]         byte_out,
	input  lsf_pkg::pattern_t  pattern,
	input  logic [LEN_W-1:0]   len,
	input  logic               fold,
	output logic               hit
);

	logic [7:0] byte_q;
	logic [4:0] len5;
	logic [4:0] diff;
	logic [3:0] sel;
	logic       in_use;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;

	// cell IDX lines up with pattern byte len-1-IDX (pattern byte 0 is oldest)
	assign len5   = 5'(len);
	assign diff   = len5 - 5'(IDX + 1);
	assign sel    = diff[3:0];
	assign in_use = (len5 > 5'(IDX));

	assign hit = !in_use ||
		(lsf_pkg::fold_byte(byte_q, fold) == lsf_pkg::fold_byte(pattern[sel], fold));

endmodule

/* design/lsf_result_fifo.sv */
// Small result queue between the compare stage and the output port.
module lsf_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lsf_pkg::result_t  push_data,
	input  logic              pop,
	output logic              out_valid,
	output lsf_pkg::result_t  out_data,
	output logic [1:0]        level
);

	lsf_pkg::result_t mem [lsf_pkg::RESULT_DEPTH];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [1:0] level_q;
	logic       do_pop;

	assign do_pop    = pop && (level_q != 2'd0);
	assign out_valid = (level_q != 2'd0);
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	assign out_data = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == 2'(lsf_pkg::RESULT_DEPTH - 1)) ? 2'd0 : wr_q + 2'd1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == 2'(lsf_pkg::RESULT_DEPTH - 1)) ? 2'd0 : rd_q + 2'd1;
			end
			case ({push, do_pop})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

/* design/line_substring_filter.sv */
// Top level of the line substring filter: window cells, compare stage, result queue.
// Throughput: one request per clock, with or without line ends, unless the result queue fills and drops s_tready.
// A line's result is registered in the compare stage (end_s1), then queued, before it shows on m_tvalid.
// The window is a row of PATTERN_MAX cells; every cell compares in the same cycle.
// Reset (arst_n low) clears the pattern registers, line count, match flag and queue.
// Window bytes are not reset; the line count keeps stale bytes out of every compare.
module line_substring_filter #(
	parameter int PATTERN_MAX = lsf_pkg::PATTERN_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tuser,   // [0] byte_valid
	input  logic        s_tlast,   // line_end
	// result stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] line_matched, [1] line_selected, [7:2] zero
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [lsf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int CNT_W = $clog2(PATTERN_MAX + 1);

	// ---------------------------------------------------------------
	// Register file. Writes are taken every cycle.
	// ---------------------------------------------------------------
	lsf_pkg::pattern_t          pattern_q;
	logic [lsf_pkg::LEN_REG_W-1:0] pat_len_q;
	logic                       fold_q;
	logic                       invert_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			pat_len_q <= '0;
			fold_q    <= 1'b0;
			invert_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				lsf_pkg::CFG_PAT_LOW:  pattern_q[7:0]  <= cfg_data;
				lsf_pkg::CFG_PAT_HIGH: pattern_q[15:8] <= cfg_data;
				lsf_pkg::CFG_PAT_LEN:  pat_len_q <= cfg_data[lsf_pkg::LEN_REG_W-1:0];
				lsf_pkg::CFG_FOLD:     fold_q    <= cfg_data[0];
				lsf_pkg::CFG_INVERT:   invert_q  <= cfg_data[0];
				default: ; // unknown index, write dropped
			endcase
		end
	end

	// lengths above the window size saturate to it
	logic [CNT_W-1:0] len_eff;
	assign len_eff = (32'(pat_len_q) > PATTERN_MAX) ? CNT_W'(PATTERN_MAX)
	                                                : CNT_W'(pat_len_q);

	// ---------------------------------------------------------------
	// Accept and line byte count.
	// ---------------------------------------------------------------
	logic             accept;
	logic             take_byte;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_next;

	assign accept    = s_tvalid && s_tready;
	assign take_byte = accept && s_tuser;

	// count saturates at the window size; that is all any compare needs
	assign cnt_next = (take_byte && (cnt_q != CNT_W'(PATTERN_MAX))) ? cnt_q + 1'b1 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= s_tlast ? '0 : cnt_next;
		end
	end

	// ---------------------------------------------------------------
	// Window: a row of cells, newest byte in cell 0, shifting on each byte.
	// ---------------------------------------------------------------
	logic [PATTERN_MAX-1:0][7:0] tap;
	logic [PATTERN_MAX-1:0]      cell_hit;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		logic [7:0] cell_in;
		if (i == 0) begin : g_head
			assign cell_in = s_tdata;
		end else begin : g_body
			assign cell_in = tap[i-1];
		end
		lsf_cell #(
			.IDX   (i),
			.LEN_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.shift_en (take_byte),
			.byte_in  (cell_in),
			.byte_out (tap[i]),
			.pattern  (pattern_q),
			.len      (len_eff),
			.fold     (fold_q),
			.hit      (cell_hit[i])
		);
	end

	// ---------------------------------------------------------------
	// Compare stage: looks at the window the cycle after the byte went in.
	// ---------------------------------------------------------------
	logic             cmp_s1;
	logic             end_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic             found_q;
	logic             tail_hit;
	logic             found_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_s1 <= 1'b0;
			end_s1 <= 1'b0;
			cnt_s1 <= '0;
		end else begin
			cmp_s1 <= take_byte;
			end_s1 <= accept && s_tlast;
			cnt_s1 <= cnt_next;
		end
	end

	// pattern must fit in the bytes seen so far
	assign tail_hit  = cmp_s1 && (len_eff != '0) && (cnt_s1 >= len_eff) && (&cell_hit);
	assign found_now = found_q || tail_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else begin
			found_q <= end_s1 ? 1'b0 : found_now;
		end
	end

	// ---------------------------------------------------------------
	// Result queue. Three slots: the queue and the compare stage together
	// never hold more, since s_tready drops while they hold three results.
	// ---------------------------------------------------------------
	lsf_pkg::result_t res_in;
	lsf_pkg::result_t res_out;
	logic [1:0]       level;
	logic [2:0]       in_flight;

	assign res_in.matched  = (len_eff == '0) || found_now;
	assign res_in.selected = ((len_eff == '0) || found_now) ^ invert_q;

	lsf_result_fifo u_results (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (end_s1),
		.push_data (res_in),
		.pop       (m_tready),
		.out_valid (m_tvalid),
		.out_data  (res_out),
		.level     (level)
	);

	assign m_tdata   = {6'b0, res_out.selected, res_out.matched};
	assign in_flight = 3'(level) + 3'(end_s1);
	assign s_tready  = (in_flight <= 3'd2);

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight <= 3'(lsf_pkg::RESULT_DEPTH))
		else $error("result queue overrun");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= PATTERN_MAX)
		else $error("line byte count beyond window");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		end_s1 |=> m_tvalid)
		else $error("line result not presented");

endmodule
